@@ rtl/assert_macros.svh @@
// assertion helpers for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

@@ rtl/etrs_pkg.sv @@
package etrs_pkg;

    localparam int unsigned CordicSteps = 16;
    localparam int unsigned FullTurn    = 23040;
    localparam int unsigned QuarterTurn = 5760;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;
    localparam logic signed [33:0] HalfLsb    = 34'sd536870912;

    typedef logic signed [33:0] q30_t;
    typedef logic signed [31:0] q16_t;
    typedef logic signed [15:0] ang_t;

    // front side item: raw fields after acceptance
    typedef struct packed {
        q16_t move_x;
        q16_t move_y;
        q16_t move_z;
        ang_t angle_x;
        ang_t angle_y;
        ang_t angle_z;
        q16_t size_x;
        q16_t size_y;
        q16_t size_z;
    } item_t;

    typedef struct packed {
        q30_t x;
        q30_t y;
        logic signed [23:0] z;
    } crd_t;

    function automatic logic signed [23:0] atan_deg(input logic [3:0] i);
        logic signed [23:0] v;
        case (i)
            4'd0:  v = 24'sd2949120;
            4'd1:  v = 24'sd1740967;
            4'd2:  v = 24'sd919879;
            4'd3:  v = 24'sd466945;
            4'd4:  v = 24'sd234379;
            4'd5:  v = 24'sd117304;
            4'd6:  v = 24'sd58666;
            4'd7:  v = 24'sd29335;
            4'd8:  v = 24'sd14668;
            4'd9:  v = 24'sd7334;
            4'd10: v = 24'sd3667;
            4'd11: v = 24'sd1833;
            4'd12: v = 24'sd917;
            4'd13: v = 24'sd458;
            4'd14: v = 24'sd229;
            default: v = 24'sd115;
        endcase
        return v;
    endfunction

    // rounded q30 product, round half up
    function automatic q30_t mul_q30(input q30_t a, input q30_t b);
        logic signed [67:0] p;
        p = 68'(a) * 68'(b) + 68'(HalfLsb);
        return q30_t'(p >>> 30);
    endfunction

    // scale by q16.16 and clamp
    function automatic q16_t scale_sat(input q30_t r, input q16_t s);
        logic signed [66:0] p;
        logic signed [36:0] v;
        p = 67'(r) * 67'(s) + 67'(HalfLsb);
        v = 37'(p >>> 30);
        if (v > 37'sd2147483647) return 32'sh7fffffff;
        if (v < -37'sd2147483648) return 32'sh80000000;
        return q16_t'(v);
    endfunction

endpackage

@@ rtl/etrs_front.sv @@
module etrs_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  etrs_pkg::item_t      in_item,
    output logic                 q_valid,
    input  logic                 q_ready,
    output etrs_pkg::item_t      q_item
);
    import etrs_pkg::*;

    // two entry queue between front and back
    item_t      buf_reg [2];
    item_t      buf_next [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next, wr_reg, wr_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        wr_next  = wr_reg;
        if (push) begin
            buf_next[wr_reg] = in_item;
            wr_next = ~wr_reg;
        end
        if (pop) rd_next = ~rd_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        else if (pop && !push) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end
endmodule

@@ rtl/etrs_back.sv @@
module etrs_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  etrs_pkg::item_t q_item,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [383:0]    out_data
);
    import etrs_pkg::*;

    localparam int unsigned Stages = CordicSteps + 5;

    // pipeline stalls as a whole when the output holds a beat that is not taken
    logic adv;
    logic [Stages-1:0] vld_reg, vld_next;

    // stage 0: angle reduction
    logic [2:0][25:0]        red;
    logic [2:0][1:0]         quad_reg [CordicSteps+1];
    crd_t [2:0]              crd_reg  [CordicSteps+1];
    logic [2:0][31:0]        size_reg [CordicSteps+4];
    logic [2:0][31:0]        move_reg [CordicSteps+4];
    q30_t [2:0]              c_reg, s_reg;
    q30_t                    sxsy_reg, cxsy_reg;
    q30_t [10:0]             p_reg;
    q30_t [8:0]              r_reg;
    logic [383:0]            data_reg;

    assign adv      = !vld_reg[Stages-1] || out_ready;
    assign q_ready  = adv;
    assign out_valid = vld_reg[Stages-1];
    assign out_data = data_reg;

    always_comb begin
        vld_next = {vld_reg[Stages-2:0], q_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= vld_next;
    end

    // wrap into one turn, then split off the quadrant; gives {quadrant, cordic angle}
    function automatic logic [25:0] reduce(input ang_t a);
        logic signed [16:0] r;
        logic [14:0] rem;
        logic [1:0] q;
        r = 17'(a);
        if (r >= 17'sd23040) r = r - 17'sd23040;
        else if (r < -17'sd23040) r = r + 17'sd46080;
        else if (r < 17'sd0) r = r + 17'sd23040;
        q = 2'd0; rem = r[14:0];
        if (rem >= 15'(3 * QuarterTurn)) begin q = 2'd3; rem = rem - 15'(3 * QuarterTurn); end
        else if (rem >= 15'(2 * QuarterTurn)) begin q = 2'd2; rem = rem - 15'(2 * QuarterTurn); end
        else if (rem >= 15'(QuarterTurn)) begin q = 2'd1; rem = rem - 15'(QuarterTurn); end
        return {q, 24'(rem) << 10};
    endfunction

    // one micro-rotation
    function automatic crd_t crd_step(input crd_t c, input logic [3:0] i);
        crd_t n;
        if (c.z >= 0) begin
            n.x = c.x - (c.y >>> i);
            n.y = c.y + (c.x >>> i);
            n.z = c.z - atan_deg(i);
        end else begin
            n.x = c.x + (c.y >>> i);
            n.y = c.y - (c.x >>> i);
            n.z = c.z + atan_deg(i);
        end
        return n;
    endfunction

    assign red[0] = reduce(q_item.angle_x);
    assign red[1] = reduce(q_item.angle_y);
    assign red[2] = reduce(q_item.angle_z);

    always_ff @(posedge aclk) begin
        crd_t f;
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                quad_reg[0][a] <= red[a][25:24];
                crd_reg[0][a]  <= '{CordicGain, '0, red[a][23:0]};
            end
            size_reg[0] <= {q_item.size_z, q_item.size_y, q_item.size_x};
            move_reg[0] <= {q_item.move_z, q_item.move_y, q_item.move_x};
            for (int k = 1; k < CordicSteps + 4; k++) begin
                size_reg[k] <= size_reg[k-1];
                move_reg[k] <= move_reg[k-1];
            end
            for (int k = 1; k <= CordicSteps; k++) quad_reg[k] <= quad_reg[k-1];
            // cordic stages, one micro-rotation per stage
            for (int i = 0; i < CordicSteps; i++)
                for (int a = 0; a < 3; a++)
                    crd_reg[i+1][a] <= crd_step(crd_reg[i][a], 4'(i));
            for (int a = 0; a < 3; a++) begin
                f = crd_reg[CordicSteps][a];
                case (quad_reg[CordicSteps][a])
                    2'd0: begin c_reg[a] <= f.x;  s_reg[a] <= f.y;  end
                    2'd1: begin c_reg[a] <= -f.y; s_reg[a] <= f.x;  end
                    2'd2: begin c_reg[a] <= -f.x; s_reg[a] <= -f.y; end
                    default: begin c_reg[a] <= f.y; s_reg[a] <= -f.x; end
                endcase
            end
            // first products
            sxsy_reg <= mul_q30(s_reg[0], s_reg[1]);
            cxsy_reg <= mul_q30(c_reg[0], s_reg[1]);
            p_reg[0]  <= mul_q30(c_reg[1], c_reg[2]);
            p_reg[1]  <= mul_q30(c_reg[1], s_reg[2]);
            p_reg[2]  <= s_reg[1];
            p_reg[3]  <= mul_q30(c_reg[0], s_reg[2]);
            p_reg[4]  <= mul_q30(c_reg[0], c_reg[2]);
            p_reg[5]  <= mul_q30(s_reg[0], c_reg[1]);
            p_reg[6]  <= mul_q30(s_reg[0], s_reg[2]);
            p_reg[7]  <= mul_q30(s_reg[0], c_reg[2]);
            p_reg[8]  <= mul_q30(c_reg[0], c_reg[1]);
            p_reg[9]  <= s_reg[2];
            p_reg[10] <= c_reg[2];
            // second products and sums
            r_reg[0] <= p_reg[0];
            r_reg[1] <= -p_reg[1];
            r_reg[2] <= p_reg[2];
            r_reg[3] <= mul_q30(sxsy_reg, p_reg[10]) + p_reg[3];
            r_reg[4] <= p_reg[4] - mul_q30(sxsy_reg, p_reg[9]);
            r_reg[5] <= -p_reg[5];
            r_reg[6] <= p_reg[6] - mul_q30(cxsy_reg, p_reg[10]);
            r_reg[7] <= mul_q30(cxsy_reg, p_reg[9]) + p_reg[7];
            r_reg[8] <= p_reg[8];
            // scaling and output
            for (int k = 0; k < 9; k++)
                data_reg[32*k +: 32] <= scale_sat(r_reg[k], size_reg[CordicSteps+3][k%3]);
            data_reg[383:288] <= move_reg[CordicSteps+3];
        end
    end
endmodule

@@ rtl/euler_trs_model_matrix.sv @@
// path from input beat to result beat: queue entry, angle reduction, 16 cordic stages,
// quadrant fix-up, two product stages, scaling stage; they stall while a result beat waits
// throughput: one transform per cycle unless stalled, set by the pipelined stages
// reset: synchronous active-low aresetn clears queue and pipeline valid flags
`include "assert_macros.svh"
module euler_trs_model_matrix (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // move_x, move_y, move_z, angle_x, angle_y, angle_z, size_x, size_y, size_z
    input  logic [239:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, col3_x, col3_y, col3_z
    output logic [383:0] m_tdata
);
    import etrs_pkg::*;

    item_t in_item, q_item;
    logic  q_valid, q_ready;

    // unpack beat fields, lowest bits first
    assign in_item.move_x  = s_tdata[31:0];
    assign in_item.move_y  = s_tdata[63:32];
    assign in_item.move_z  = s_tdata[95:64];
    assign in_item.angle_x = s_tdata[111:96];
    assign in_item.angle_y = s_tdata[127:112];
    assign in_item.angle_z = s_tdata[143:128];
    assign in_item.size_x  = s_tdata[175:144];
    assign in_item.size_y  = s_tdata[207:176];
    assign in_item.size_z  = s_tdata[239:208];

    // front: accept and buffer beats
    etrs_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item,
        .q_valid, .q_ready, .q_item
    );

    // back: trig, matrix products, scaling
    etrs_back u_back (
        .aclk, .aresetn,
        .q_valid, .q_ready, .q_item,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
    );

    `ASSERT_CLK(a_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> m_tvalid, "result beat dropped")
    `ASSERT_CLK(a_q, aclk, aresetn, (q_valid && !q_ready) |=> q_valid, "queue entry lost")
endmodule

@@ test/euler_trs_model_matrix_tb.sv @@
`timescale 1ns / 100ps
module euler_trs_model_matrix_tb;
    import etrs_pkg::*;

    typedef struct {
        logic [31:0] move_x, move_y, move_z;
        logic [15:0] angle_x, angle_y, angle_z;
        logic [31:0] size_x, size_y, size_z;
    } xform_t;

    // twelve 32 bit entries: nine matrix entries then the translation column
    typedef logic [383:0] matrix_t;

    // gain-compensated start vector and atan table, degrees in q16
    localparam longint StartX = 652032874;
    localparam int CycleLimit = 400000;
    localparam int PipeDepth = 23;
    longint atan_tab [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                              29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // move_x, move_y, move_z, angle_x, angle_y, angle_z, size_x, size_y, size_z
    logic [239:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, col3_x, col3_y, col3_z
    logic [383:0] m_tdata;

    matrix_t pending_matrices[$];
    int      fail_count;
    int      cycle_count;
    bit      hold_off_req;   // asks the sink process for one long stall

    euler_trs_model_matrix dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // floor division by a power of two
    function automatic longint fshift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint rmul(longint a, longint b);
        return fshift(a * b + (64'sd1 << 29), 30);
    endfunction

    // cordic sine and cosine in q2.30, angle in q10.6 degrees wrapping at one turn
    task automatic angle_to_cos_sin(input logic [15:0] ang, output longint c,
                                    output longint s);
        longint r, q, x, y, z, xs, ys;
        r = longint'($signed(ang)) % 23040;
        if (r < 0) r += 23040;
        q = r / 5760;
        x = StartX;
        y = 0;
        z = (r - q * 5760) * 1024;
        for (int i = 0; i < 16; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_tab[i];
            end else begin
                x += ys; y -= xs; z += atan_tab[i];
            end
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    // scale a q30 rotation entry by a q16.16 factor and clamp to 32 bits
    function automatic logic [31:0] scaled_entry(longint rq, logic [31:0] sz);
        longint v;
        v = fshift(rq * longint'($signed(sz)) + (64'sd1 << 29), 30);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    task automatic predict_matrix(input xform_t t, output matrix_t m);
        longint cx, sx, cy, sy, cz, sz, sxsy, cxsy;
        longint r [9];
        logic [31:0] sc [3];
        angle_to_cos_sin(t.angle_x, cx, sx);
        angle_to_cos_sin(t.angle_y, cy, sy);
        angle_to_cos_sin(t.angle_z, cz, sz);
        sc[0] = t.size_x; sc[1] = t.size_y; sc[2] = t.size_z;
        sxsy = rmul(sx, sy);
        cxsy = rmul(cx, sy);
        r[0] = rmul(cy, cz);
        r[1] = -rmul(cy, sz);
        r[2] = sy;
        r[3] = rmul(sxsy, cz) + rmul(cx, sz);
        r[4] = rmul(cx, cz) - rmul(sxsy, sz);
        r[5] = -rmul(sx, cy);
        r[6] = rmul(sx, sz) - rmul(cxsy, cz);
        r[7] = rmul(cxsy, sz) + rmul(sx, cz);
        r[8] = rmul(cx, cy);
        m = '0;
        for (int k = 0; k < 9; k++) m[k*32 +: 32] = scaled_entry(r[k], sc[k % 3]);
        m[288 +: 32] = t.move_x;
        m[320 +: 32] = t.move_y;
        m[352 +: 32] = t.move_z;
    endtask

    // no gap half the time, otherwise mostly a short gap and now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    bit gaps_on;

    // offer one transform, keeping valid high until the handshake
    task automatic send_xform(input xform_t t);
        matrix_t m;
        int g;
        g = gaps_on ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        predict_matrix(t, m);
        s_tdata  <= {t.size_z, t.size_y, t.size_x, t.angle_z, t.angle_y, t.angle_x,
                     t.move_z, t.move_y, t.move_x};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_matrices.push_back(m);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(1, 0) ? 32'h0001_0000 : 32'hffff_0000;
            3: return 32'($signed($urandom_range(8 << 16, 0)) - (4 << 16));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(4))
            0: return 16'($urandom_range(3, 0) * 5760);
            1: return 16'(-$signed($urandom_range(23040, 0)));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic xform_t rand_xform();
        xform_t t;
        t.move_x = $urandom; t.move_y = $urandom; t.move_z = $urandom;
        t.angle_x = rand_angle(); t.angle_y = rand_angle(); t.angle_z = rand_angle();
        t.size_x = rand_word(); t.size_y = rand_word(); t.size_z = rand_word();
        return t;
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_matrices.size() != 0) @(posedge aclk);
    endtask

    // field extremes, quadrant edges, wrap past one turn, saturating scales
    task automatic test_directed();
        xform_t t;
        logic [15:0] angs [8] = '{16'h0000, 16'd5760, 16'd11520, 16'd17280, 16'd23040,
                                  16'h7fff, 16'h8000, 16'hffff};
        logic [31:0] words [6] = '{32'h0, 32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff,
                                   32'h8000_0000, 32'hffff_ffff};
        for (int i = 0; i < 8; i++) begin
            t.move_x = words[i % 6]; t.move_y = words[(i + 2) % 6];
            t.move_z = words[(i + 4) % 6];
            t.angle_x = angs[i]; t.angle_y = angs[(i + 3) % 8]; t.angle_z = angs[(i + 5) % 8];
            t.size_x = 32'h0001_0000; t.size_y = 32'h0001_0000; t.size_z = 32'h0001_0000;
            send_xform(t);
        end
        for (int i = 0; i < 6; i++) begin
            t.move_x = words[(i + 1) % 6]; t.move_y = words[i]; t.move_z = words[(i + 3) % 6];
            t.angle_x = 16'd2880; t.angle_y = 16'hf4c0; t.angle_z = 16'd1920;
            t.size_x = words[i]; t.size_y = words[(i + 4) % 6]; t.size_z = words[(i + 5) % 6];
            send_xform(t);
        end
        wait_drained();
    endtask

    task automatic test_random(input int n);
        repeat (n) send_xform(rand_xform());
    endtask

    // sink stalls for a long stretch while the source keeps offering
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        gaps_on = 1'b0;
        test_random(60);
        gaps_on = 1'b1;
        wait_drained();
    endtask

    // sink side: random ready with gaps, one long stall on request
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (200) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(3) != 0) || !gaps_on;
                @(posedge aclk);
            end
        end
    end

    // result checker, compares each beat with the oldest prediction
    always @(posedge aclk) begin
        matrix_t exp_m;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_matrices.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, m_tdata);
                fail_count++;
            end else begin
                exp_m = pending_matrices.pop_front();
                for (int k = 0; k < 12; k++)
                    if (m_tdata[k*32 +: 32] !== exp_m[k*32 +: 32]) begin
                        $display("%0t: field %0d expected %h actual %h", $time, k,
                                 exp_m[k*32 +: 32], m_tdata[k*32 +: 32]);
                        fail_count++;
                    end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        fail_count = 0;
        cycle_count = 0;
        hold_off_req = 1'b0;
        gaps_on = 1'b1;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(200);
        // source pauses until everything is back, then carries on
        wait_drained();
        test_backpressure();
        test_random(280);
        wait_drained();
        repeat (PipeDepth + 10) @(posedge aclk);
        if (fail_count == 0 && pending_matrices.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
